// ----- rtl/core/rcfsd_pkg.sv -----
// ============================================================================
// rcfsd_pkg: shared types and constants of the radio-link frame decoder
// Holds the frame layout, the divide-by-fifty reciprocal and the stage records.
// ============================================================================
package rcfsd_pkg;

    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 24;
    localparam int TARGET_W  = 20;
    localparam int QUO_W     = 19;
    localparam int IDX_W     = 4;
    localparam int SYNC_W    = 2;
    localparam int STORE_W   = 72;

    localparam logic [BYTE_W-1:0]  SYNC_BYTE    = 8'hF0;
    localparam logic [SYNC_W-1:0]  SYNC_LOCKED  = 2'd3;
    localparam logic [IDX_W-1:0]   STORED_LEN   = 4'd9;
    localparam logic [IDX_W-1:0]   LAST_IDX     = 4'd11;
    localparam logic [VALUE_W-1:0] CENTER_RESET = 24'd1500;

    // Magnitude / 50 as (m * RECIP_K) >> RECIP_SHIFT, exact for all m below 2^24.
    localparam int                 RECIP_SHIFT = 30;
    localparam int                 RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP_K     = 25'd21474837;
    localparam int                 PROD_W      = VALUE_W + RECIP_W;

    typedef logic [VALUE_W-1:0]         t_value;
    typedef logic [QUO_W-1:0]           t_quo;
    typedef logic signed [TARGET_W-1:0] t_target;

    // Raw frame values captured on the last payload byte.
    typedef struct packed {
        t_value speed;
        t_value x;
        t_value y;
    } t_s1;

    // Magnitudes and signs of the stick offsets.
    typedef struct packed {
        t_value speed;
        t_value mag_x;
        logic   neg_x;
        t_value mag_y;
        logic   neg_y;
    } t_s2;

    // Truncated quotients and their signs.
    typedef struct packed {
        t_value speed;
        t_quo   q_x;
        logic   neg_x;
        t_quo   q_y;
        logic   neg_y;
    } t_s3;

    // Result item, speed in the lowest bits.
    typedef struct packed {
        t_target pitch_target;
        t_target roll_target;
        t_value  motor_speed;
    } t_result;

endpackage

// ----- rtl/core/rc_frame_sync_decoder_unit.sv -----
// ============================================================================
// rc_frame_sync_decoder_unit: radio-link control frame decoder
// Hunts for three 0xF0 sync bytes, gathers a twelve-byte payload and turns it
// into a motor speed and roll and pitch targets.
// ============================================================================
// A result is presented on m_tvalid once the last payload byte of its frame
// has passed the capture, offset, divide and sign stages. Throughput: one byte
// per cycle while s_tready is high, set by the byte parser, which
// updates its state at every accepted item. Reset (i_rst_n low at a rising
// edge) clears the parser and all stage valid flags and restores the stick
// centre to 1500; the payload store and stage data are not reset.
// ============================================================================
module rc_frame_sync_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: stick_center
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    // Byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [23:0] motor_speed, [43:24] roll_target,
                                   // [63:44] pitch_target
);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    rcfsd_pkg::t_value                     r_center;
    logic [rcfsd_pkg::SYNC_W-1:0]          r_sync_seen;
    logic [rcfsd_pkg::IDX_W-1:0]           r_payload_idx;
    logic [rcfsd_pkg::STORE_W-1:0]         r_store;

    logic                                  r_s1_valid;
    logic                                  r_s2_valid;
    logic                                  r_s3_valid;
    logic                                  r_out_valid;
    rcfsd_pkg::t_s1                        r_s1;
    rcfsd_pkg::t_s2                        r_s2;
    rcfsd_pkg::t_s3                        r_s3;
    rcfsd_pkg::t_result                    r_out;

    // ------------------------------------------------------------------------
    // Flow control. Each stage moves on when the one after it is empty or is
    // moving on itself, so a waiting result does not stop the byte stream
    // unless every stage is full.
    // ------------------------------------------------------------------------
    logic out_ready;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_accept;
    logic frame_done;

    assign out_ready = !r_out_valid || m_tready;
    assign s3_ready  = !r_s3_valid || out_ready;
    assign s2_ready  = !r_s2_valid || s3_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;

    assign s_tready  = s1_ready;
    assign in_accept = s_tvalid && s1_ready;

    // The twelfth payload byte closes the frame.
    assign frame_done = in_accept && (r_sync_seen == rcfsd_pkg::SYNC_LOCKED)
                        && (r_payload_idx == rcfsd_pkg::LAST_IDX);

    // ------------------------------------------------------------------------
    // Byte parser. While hunting, sync_seen counts consecutive sync bytes; once
    // it reaches three, every byte is payload, sync bytes included, until the
    // twelfth one. Only the first nine bytes (speed, X, Y) are kept; the Z
    // bytes are counted and dropped.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center      <= rcfsd_pkg::CENTER_RESET;
            r_sync_seen   <= '0;
            r_payload_idx <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_center <= i_cfg_wr_data;
            end
            if (in_accept) begin
                if (r_sync_seen != rcfsd_pkg::SYNC_LOCKED) begin
                    if (s_tdata == rcfsd_pkg::SYNC_BYTE) begin
                        r_sync_seen <= r_sync_seen + 1'b1;
                    end else begin
                        r_sync_seen <= '0;
                    end
                    r_payload_idx <= '0;
                end else if (r_payload_idx == rcfsd_pkg::LAST_IDX) begin
                    r_sync_seen   <= '0;
                    r_payload_idx <= '0;
                end else begin
                    r_payload_idx <= r_payload_idx + 1'b1;
                end
            end
        end
    end

    // Payload bytes shift in at the bottom, so after nine bytes the speed sits
    // in the top 24 bits and Y in the bottom 24 bits.
    always_ff @(posedge i_clk) begin
        if (in_accept && (r_sync_seen == rcfsd_pkg::SYNC_LOCKED)
                && (r_payload_idx < rcfsd_pkg::STORED_LEN)) begin
            r_store <= {r_store[rcfsd_pkg::STORE_W-rcfsd_pkg::BYTE_W-1:0], s_tdata};
        end
    end

    // ------------------------------------------------------------------------
    // Offset stage: both X - centre and centre - X are formed side by side and
    // the borrow picks the non-negative one as the magnitude.
    // ------------------------------------------------------------------------
    logic [rcfsd_pkg::VALUE_W:0]   fwd_x;
    logic [rcfsd_pkg::VALUE_W:0]   fwd_y;
    rcfsd_pkg::t_value             rev_x;
    rcfsd_pkg::t_value             rev_y;
    rcfsd_pkg::t_s2                n_s2;

    always_comb begin
        fwd_x = {1'b0, r_s1.x} - {1'b0, r_center};
        fwd_y = {1'b0, r_s1.y} - {1'b0, r_center};
        rev_x = r_center - r_s1.x;
        rev_y = r_center - r_s1.y;
        n_s2.speed = r_s1.speed;
        n_s2.neg_x = fwd_x[rcfsd_pkg::VALUE_W];
        n_s2.neg_y = fwd_y[rcfsd_pkg::VALUE_W];
        n_s2.mag_x = fwd_x[rcfsd_pkg::VALUE_W] ? rev_x : fwd_x[rcfsd_pkg::VALUE_W-1:0];
        n_s2.mag_y = fwd_y[rcfsd_pkg::VALUE_W] ? rev_y : fwd_y[rcfsd_pkg::VALUE_W-1:0];
    end

    // ------------------------------------------------------------------------
    // Divide stage: magnitude / 50 by a reciprocal multiply, which is exact
    // for every 24-bit magnitude, so the quotient truncates toward zero once
    // the sign is put back.
    // ------------------------------------------------------------------------
    logic [rcfsd_pkg::PROD_W-1:0]  prod_x;
    logic [rcfsd_pkg::PROD_W-1:0]  prod_y;
    rcfsd_pkg::t_s3                n_s3;

    always_comb begin
        prod_x = rcfsd_pkg::PROD_W'(r_s2.mag_x) * rcfsd_pkg::PROD_W'(rcfsd_pkg::RECIP_K);
        prod_y = rcfsd_pkg::PROD_W'(r_s2.mag_y) * rcfsd_pkg::PROD_W'(rcfsd_pkg::RECIP_K);
        n_s3.speed = r_s2.speed;
        n_s3.q_x   = prod_x[rcfsd_pkg::RECIP_SHIFT +: rcfsd_pkg::QUO_W];
        n_s3.q_y   = prod_y[rcfsd_pkg::RECIP_SHIFT +: rcfsd_pkg::QUO_W];
        n_s3.neg_x = r_s2.neg_x;
        n_s3.neg_y = r_s2.neg_y;
    end

    // ------------------------------------------------------------------------
    // Sign stage: roll keeps the sign of the X offset, pitch takes the
    // opposite sign of the Y offset because its divisor is minus fifty.
    // ------------------------------------------------------------------------
    rcfsd_pkg::t_target  ext_x;
    rcfsd_pkg::t_target  ext_y;
    rcfsd_pkg::t_result  n_out;

    always_comb begin
        ext_x = rcfsd_pkg::t_target'({1'b0, r_s3.q_x});
        ext_y = rcfsd_pkg::t_target'({1'b0, r_s3.q_y});
        n_out.motor_speed  = r_s3.speed;
        n_out.roll_target  = r_s3.neg_x ? -ext_x : ext_x;
        n_out.pitch_target = r_s3.neg_y ? ext_y : -ext_y;
    end

    // ------------------------------------------------------------------------
    // Stage valid flags and data
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= frame_done;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_s1.speed <= r_store[2*rcfsd_pkg::VALUE_W +: rcfsd_pkg::VALUE_W];
            r_s1.x     <= r_store[rcfsd_pkg::VALUE_W +: rcfsd_pkg::VALUE_W];
            r_s1.y     <= r_store[0 +: rcfsd_pkg::VALUE_W];
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
        if (s3_ready && r_s2_valid) begin
            r_s3 <= n_s3;
        end
        if (out_ready && r_s3_valid) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

`ifndef NO_ASSERTIONS
    // Outside a payload the byte counter rests at zero.
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sync_seen != rcfsd_pkg::SYNC_LOCKED) |-> (r_payload_idx == '0))
        else $error("payload index moved while hunting for sync");

    // The byte counter never runs past the last payload byte.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_payload_idx <= rcfsd_pkg::LAST_IDX)
        else $error("payload index beyond frame length");

    // A closed frame always reaches the capture stage and the parser rehunts.
    a_frame_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_done |=> (r_s1_valid && (r_sync_seen == '0) && (r_payload_idx == '0)))
        else $error("closed frame was not captured");

    // Targets stay within what a 24-bit offset divided by fifty can give.
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.roll_target >= -20'sd335545)
                         && (r_out.roll_target <= 20'sd335545)
                         && (r_out.pitch_target >= -20'sd335545)
                         && (r_out.pitch_target <= 20'sd335545)))
        else $error("target out of range");
`endif

endmodule

// ----- tb/tb_rc_frame_sync_decoder_unit.sv -----
// ============================================================================
// tb_rc_frame_sync_decoder_unit: self-checking bench for the radio-link frame decoder
// Feeds byte streams with and without valid sync runs. A local decoder model
// predicts every motor speed and roll and pitch target, and each result
// leaving the block is checked field by field against the oldest prediction.
// ============================================================================
module tb_rc_frame_sync_decoder_unit;

    // The drain allowance covers the capture, offset, divide and sign stages of
    // the block, with some margin.
    localparam int DRAIN_CYCLES   = 8;
    localparam int TARGET_DIVISOR = 50;
    localparam int PHASE_ITEMS    = 320;

    // One row of the directed script. Where pinned is set, the row completes
    // a frame whose result can be worked out by hand, and that value is
    // checked instead of the prediction.
    typedef struct packed {
        logic [7:0]         rx;
        logic               pinned;
        rcfsd_pkg::t_result val;
    } t_script_row;

    // Result of the directed frame at the reset centre of 1500. Speed is
    // 0xF0FFFF, stick X is 0 and stick Y is 0xFFFFFF:
    // roll = -1500 / 50 = -30, pitch = -(16775715 / 50) = -335514.
    localparam rcfsd_pkg::t_result FRAME_A_RESULT = '{
        pitch_target: -20'sd335514,
        roll_target:  -20'sd30,
        motor_speed:  24'hF0FFFF
    };

    localparam int SCRIPT_LEN = 20;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [23:0] i_cfg_wr_data = '0;
    logic        s_tvalid      = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata       = '0;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready      = 1'b0;
    logic [63:0] m_tdata;               // [23:0] motor_speed, [43:24] roll_target,
                                        // [63:44] pitch_target

    rc_frame_sync_decoder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The run is ended here if the block stops producing results.
    initial begin
        #4_000_000;
        $display("rc_frame_sync_decoder_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Decoder model. It keeps its own copy of the parser state and of the
    // stick centre, and is stepped once for every byte the block accepts.
    // ------------------------------------------------------------------------
    int                sync_run;
    int                payload_pos;
    logic [7:0]        frame_bytes [9];
    rcfsd_pkg::t_value stick_centre = rcfsd_pkg::CENTER_RESET;

    rcfsd_pkg::t_result pending_results [$];  // predictions still waiting for the block
    t_script_row        script_pins [$];      // one entry per byte sent, in order
    int                 fail_count = 0;
    int                 items_sent = 0;
    int                 burst_left = 0;

    function automatic bit decode_rx_byte(input logic [7:0] rx,
                                          output rcfsd_pkg::t_result res);
        rcfsd_pkg::t_value spd;
        rcfsd_pkg::t_value stick_x;
        rcfsd_pkg::t_value stick_y;
        longint dx;
        longint dy;
        longint roll;
        longint pitch;
        res = '0;
        // While hunting, count consecutive sync bytes; anything else starts
        // the count again.
        if (sync_run < rcfsd_pkg::SYNC_LOCKED) begin
            if (rx == rcfsd_pkg::SYNC_BYTE) begin
                sync_run++;
            end else begin
                sync_run = 0;
            end
            payload_pos = 0;
            return 1'b0;
        end
        // Locked: every byte is payload, sync bytes included. The Z bytes are
        // counted but not kept.
        if (payload_pos < rcfsd_pkg::STORED_LEN) begin
            frame_bytes[payload_pos] = rx;
        end
        if (payload_pos < rcfsd_pkg::LAST_IDX) begin
            payload_pos++;
            return 1'b0;
        end
        sync_run    = 0;
        payload_pos = 0;
        spd     = {frame_bytes[0], frame_bytes[1], frame_bytes[2]};
        stick_x = {frame_bytes[3], frame_bytes[4], frame_bytes[5]};
        stick_y = {frame_bytes[6], frame_bytes[7], frame_bytes[8]};
        dx    = longint'(stick_x) - longint'(stick_centre);
        dy    = longint'(stick_y) - longint'(stick_centre);
        // Integer division in SystemVerilog truncates toward zero.
        roll  = dx / TARGET_DIVISOR;
        pitch = -(dy / TARGET_DIVISOR);
        res.motor_speed  = spd;
        res.roll_target  = roll[19:0];
        res.pitch_target = pitch[19:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Results are checked before the byte of the same edge is
    // predicted; a result can never belong to a byte accepted at the same
    // edge, as the block registers each frame through its stages.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rcfsd_pkg::t_result got;
        rcfsd_pkg::t_result want;
        rcfsd_pkg::t_result fresh;
        t_script_row        pin;
        bit                 made;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.motor_speed !== want.motor_speed) begin
                    $error("motor_speed: expected %0d, got %0d",
                           want.motor_speed, got.motor_speed);
                    fail_count++;
                end
                if (got.roll_target !== want.roll_target) begin
                    $error("roll_target: expected %0d, got %0d",
                           want.roll_target, got.roll_target);
                    fail_count++;
                end
                if (got.pitch_target !== want.pitch_target) begin
                    $error("pitch_target: expected %0d, got %0d",
                           want.pitch_target, got.pitch_target);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && s_tvalid && s_tready) begin
            pin  = (script_pins.size() != 0) ? script_pins.pop_front() : '0;
            made = decode_rx_byte(s_tdata, fresh);
            if (pin.pinned) begin
                if (!made) begin
                    $error("frame_done: expected 1, got 0");
                    fail_count++;
                end else begin
                    pending_results.push_back(pin.val);
                end
            end else if (made) begin
                pending_results.push_back(fresh);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It changes between always ready, coin-toss ready, ready one
    // cycle in four and long stalls, each for a random stretch of cycles.
    // ------------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    int unsigned stall_tick = 0;

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (stall_tick[1:0] == 2'd0);
            end
            default: begin
                m_tready <= (stall_tick[4:0] >= 5'd20);
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender. Items go out in bursts of random length; before a new burst the
    // stream may fall silent for a random gap.
    // ------------------------------------------------------------------------
    task automatic push_rx_byte(input logic [7:0] rx, input t_script_row pin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        script_pins.push_back(pin);
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    // Stick centre writes happen with the pipeline empty: the sender holds off
    // until every predicted result has arrived and the drain time has passed.
    task automatic set_stick_centre(input rcfsd_pkg::t_value centre);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= centre;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        stick_centre  = centre;
        burst_left    = 0;
    endtask

    // Payload values lean towards the extremes and towards the current
    // centre, where the targets are small and truncation is most visible.
    function automatic rcfsd_pkg::t_value pick_value();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2, 3: return rcfsd_pkg::t_value'(stick_centre + $urandom_range(0, 10000) - 5000);
            4: return {rcfsd_pkg::SYNC_BYTE, 16'($urandom)};
            default: return rcfsd_pkg::t_value'($urandom);
        endcase
    endfunction

    task automatic send_plain(input logic [7:0] rx);
        push_rx_byte(rx, '0);
    endtask

    task automatic send_non_sync();
        logic [7:0] rx;
        rx = 8'($urandom);
        if (rx == rcfsd_pkg::SYNC_BYTE) begin
            rx = 8'h0F;
        end
        send_plain(rx);
    endtask

    task automatic send_value(input rcfsd_pkg::t_value v);
        send_plain(v[23:16]);
        send_plain(v[15:8]);
        send_plain(v[7:0]);
    endtask

    // A frame, sometimes preceded by line noise or a sync run that breaks off.
    // The noise ends on a byte other than sync, so the frame itself locks
    // cleanly; only a lone stray sync byte in front breaks this.
    task automatic send_frame();
        int noise;
        case ($urandom_range(0, 9))
            6, 7: begin
                noise = $urandom_range(0, 3);
                repeat (noise) send_plain(8'($urandom));
                send_non_sync();
            end
            8: begin
                noise = $urandom_range(1, 2);
                repeat (noise) send_plain(rcfsd_pkg::SYNC_BYTE);
                send_non_sync();
            end
            9: begin
                // A stray sync byte in front makes the run four long, so the
                // frame is taken one byte early and its last byte is hunted.
                send_plain(rcfsd_pkg::SYNC_BYTE);
            end
            default: begin
            end
        endcase
        repeat (3) send_plain(rcfsd_pkg::SYNC_BYTE);
        send_value(pick_value());
        send_value(pick_value());
        send_value(pick_value());
        send_value(rcfsd_pkg::t_value'($urandom));
    endtask

    task automatic run_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_frame();
    endtask

    t_script_row script [SCRIPT_LEN];

    initial begin
        rcfsd_pkg::t_value spot_centre;

        // Directed stimulus: noise, a sync run broken by a zero, then a frame
        // whose first payload byte is itself a sync byte, with extreme stick
        // values and a Z value made of sync bytes.
        script = '{
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hF0, 1'b0, '0},
            '{8'hF0, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hF0, 1'b0, '0},
            '{8'hF0, 1'b0, '0},
            '{8'hF0, 1'b0, '0},
            '{8'hF0, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hF0, 1'b0, '0},
            '{8'hF0, 1'b0, '0},
            '{8'hF0, 1'b1, FRAME_A_RESULT}
        };

        // Synchronous reset, held low from the start of the run.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            push_rx_byte(script[i].rx, script[i]);
        end

        // Random frames over a sweep of stick centres, extremes included.
        spot_centre = rcfsd_pkg::t_value'($urandom);
        set_stick_centre('0);
        run_phase(PHASE_ITEMS);
        set_stick_centre('1);
        run_phase(PHASE_ITEMS);
        set_stick_centre(spot_centre);
        run_phase(PHASE_ITEMS);
        set_stick_centre(rcfsd_pkg::CENTER_RESET);
        run_phase(PHASE_ITEMS);
        set_stick_centre(24'h800000);
        run_phase(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("rc_frame_sync_decoder_unit: match");
        end else begin
            $display("rc_frame_sync_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
